// ===== src/mme_pkg.sv =====
// Shared types and constants for the matrix multiply engine.
// Used by the request/result interfaces, the controller, the cells and the top level.
package mme_pkg;

    localparam int DEF_MAX_DIM = 16;
    localparam int DIM_LIMIT   = 16;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int DOT_W   = 38;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS  = 2'd0,
        CFG_COLS  = 2'd1,
        CFG_INNER = 2'd2,
        CFG_TRANS = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DRAIN
    } t_state;

    // One A element travelling down the row of cells.
    typedef struct packed {
        logic              vld;
        logic              first;
        logic              last;
        logic [IDX_W-1:0]  p;
        logic [ELEM_W-1:0] a;
    } t_feed;

    // Write of one B element, broadcast to every cell.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  p;
        logic [ELEM_W-1:0] data;
    } t_bwr;

endpackage

// ===== src/mme_req_if.sv =====
// Request channel of the matrix multiply engine: valid/ready plus one request.
// Depends on mme_pkg for the field widths.
interface mme_req_if;
    logic                          valid;
    logic                          ready;
    logic [mme_pkg::OP_W-1:0]      op;
    logic [mme_pkg::IDX_W-1:0]     row_index;
    logic [mme_pkg::IDX_W-1:0]     col_index;
    logic signed [mme_pkg::ELEM_W-1:0] element;

    modport source (output valid, op, row_index, col_index, element, input ready);
    modport sink   (input valid, op, row_index, col_index, element, output ready);
endinterface

// ===== src/mme_rsp_if.sv =====
// Result channel of the matrix multiply engine: valid/ready plus one product element.
// Depends on mme_pkg for the field widths.
interface mme_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [mme_pkg::IDX_W-1:0]         out_row;
    logic [mme_pkg::IDX_W-1:0]         out_col;
    logic signed [mme_pkg::DOT_W-1:0]  dot_value;
    logic                              last;

    modport source (output valid, out_row, out_col, dot_value, last, input ready);
    modport sink   (input valid, out_row, out_col, dot_value, last, output ready);
endinterface

// ===== src/mme_cell.sv =====
// One cell of the product row: holds one column of B and one dot-product accumulator.
// Depends on mme_pkg; passes each A element on to its right neighbor through a register.
module mme_cell #(
    parameter int MAX_DIM  = mme_pkg::DEF_MAX_DIM,
    parameter int CELL_IDX = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mme_pkg::t_feed                      i_feed,
    input  mme_pkg::t_bwr                       i_bwr,
    output mme_pkg::t_feed                      o_feed,
    output logic signed [mme_pkg::DOT_W-1:0]    o_acc,
    output logic                                o_done
);
    import mme_pkg::*;

    localparam int CAP   = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;
    localparam int IW    = $clog2(CAP);
    localparam int DEPTH = 2 ** IW;

    logic signed [ELEM_W-1:0] r_bmem [DEPTH];
    logic signed [ELEM_W-1:0] r_b;
    t_feed                    r_fwd;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic                     r_pfirst;
    logic                     r_plast;
    logic signed [DOT_W-1:0]  r_acc;
    logic                     r_done;
    logic signed [DOT_W-1:0]  prod_ext;

    // Column store: written by B loads for this column, read by the passing element.
    always_ff @(posedge i_clk) begin
        if (i_bwr.en && (i_bwr.col == IDX_W'(CELL_IDX))) begin
            r_bmem[i_bwr.p[IW-1:0]] <= i_bwr.data;
        end
        r_b <= r_bmem[i_feed.p[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd.vld <= 1'b0;
            r_pv      <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_fwd  <= i_feed;
            r_pv   <= r_fwd.vld;
            r_done <= r_pv && r_plast;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pfirst <= r_fwd.first;
        r_plast  <= r_fwd.last;
        r_prod   <= $signed(r_fwd.a) * r_b;
        if (r_pv) begin
            r_acc <= r_pfirst ? prod_ext : (r_acc + prod_ext);
        end
    end

    assign prod_ext = {{(DOT_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign o_feed   = r_fwd;
    assign o_acc    = r_acc;
    assign o_done   = r_done;

endmodule

// ===== src/mme_ctrl.sv =====
// Controller: size registers, A store, request decode, element issue and result drain.
// Depends on mme_pkg and the request/result interfaces; drives the head of the cell row.
module mme_ctrl #(
    parameter int MAX_DIM = mme_pkg::DEF_MAX_DIM
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mme_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    mme_req_if.sink                             i_req,
    mme_rsp_if.source                           o_rsp,
    output mme_pkg::t_feed                      o_feed,
    output mme_pkg::t_bwr                       o_bwr,
    input  logic signed [mme_pkg::DOT_W-1:0]    i_acc [(MAX_DIM < mme_pkg::DIM_LIMIT) ?
                                                        MAX_DIM : mme_pkg::DIM_LIMIT],
    input  logic [((MAX_DIM < mme_pkg::DIM_LIMIT) ? MAX_DIM : mme_pkg::DIM_LIMIT)-1:0] i_done
);
    import mme_pkg::*;

    localparam int CAP    = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;
    localparam int IW     = $clog2(CAP);
    localparam int ADEPTH = 2 ** (2 * IW);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_rows, r_cols, r_inner;
    logic             r_trans;
    logic [CNT_W-1:0] rows, cols, inner;

    logic [ELEM_W-1:0] r_amem [ADEPTH];
    logic [ELEM_W-1:0] r_a_q;
    logic              r_rd_vld;
    logic              r_rd_last;
    logic [IDX_W-1:0]  r_rd_p;

    logic [IDX_W-1:0] r_row;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_col;
    logic             r_zero;

    logic                    r_ov;
    logic [IDX_W-1:0]        r_orow, r_ocol;
    logic signed [DOT_W-1:0] r_oval;
    logic                    r_olast;

    logic             req_take;
    logic             ld_a_ok, ld_b_ok, cmp_ok;
    logic [IDX_W-1:0] b_p, b_j;
    logic             issue_last;
    logic             drain_go, drain_last;
    logic [CNT_W-1:0] cols_m1;
    logic [2*IW-1:0]  rd_addr;

    // A count above the supported size acts as that size.
    assign rows  = (r_rows  > CAP_CNT) ? CAP_CNT : r_rows;
    assign cols  = (r_cols  > CAP_CNT) ? CAP_CNT : r_cols;
    assign inner = (r_inner > CAP_CNT) ? CAP_CNT : r_inner;
    assign cols_m1 = cols - 1'b1;
    assign rd_addr = {r_row[IW-1:0], r_cnt[IW-1:0]};

    always_comb begin
        n_state     = r_state;
        i_req.ready = (r_state == ST_IDLE);
        req_take    = i_req.valid && i_req.ready;
        b_p = r_trans ? i_req.col_index : i_req.row_index;
        b_j = r_trans ? i_req.row_index : i_req.col_index;
        ld_a_ok = req_take && (i_req.op == OP_LOAD_A) &&
                  ({1'b0, i_req.row_index} < rows) && ({1'b0, i_req.col_index} < inner);
        ld_b_ok = req_take && (i_req.op == OP_LOAD_B) &&
                  ({1'b0, b_p} < inner) && ({1'b0, b_j} < cols);
        cmp_ok  = req_take && (i_req.op == OP_COMPUTE) &&
                  ({1'b0, i_req.row_index} < rows) && (cols != '0);
        issue_last = (r_cnt == inner - 1'b1);
        drain_go   = (r_state == ST_DRAIN) && (!r_ov || o_rsp.ready);
        drain_last = (r_col == cols_m1);
        case (r_state)
            ST_IDLE: begin
                if (cmp_ok) begin
                    n_state = (inner == '0) ? ST_DRAIN : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (issue_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // The last column's cell finishes after those of all lower columns.
                if (i_done[cols_m1[IW-1:0]]) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_go && drain_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rows   <= COUNT_RESET;
            r_cols   <= COUNT_RESET;
            r_inner  <= COUNT_RESET;
            r_trans  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ROWS:  r_rows  <= i_cfg_data;
                    CFG_COLS:  r_cols  <= i_cfg_data;
                    CFG_INNER: r_inner <= i_cfg_data;
                    CFG_TRANS: r_trans <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            r_rd_vld <= (r_state == ST_ISSUE);
            if (drain_go) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_a_ok) begin
            r_amem[{i_req.row_index[IW-1:0], i_req.col_index[IW-1:0]}] <= i_req.element;
        end
        r_a_q <= r_amem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_rd_p    <= IDX_W'(r_cnt);
        r_rd_last <= issue_last;
        if (cmp_ok) begin
            r_row  <= i_req.row_index;
            r_zero <= (inner == '0);
            r_cnt  <= '0;
            r_col  <= '0;
        end else if (r_state == ST_ISSUE) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (drain_go) begin
            r_col <= r_col + 1'b1;
        end
        if (drain_go) begin
            r_orow  <= r_row;
            r_ocol  <= IDX_W'(r_col);
            r_oval  <= r_zero ? '0 : i_acc[r_col[IW-1:0]];
            r_olast <= drain_last;
        end
    end

    assign o_feed.vld   = r_rd_vld;
    assign o_feed.first = (r_rd_p == '0);
    assign o_feed.last  = r_rd_last;
    assign o_feed.p     = r_rd_p;
    assign o_feed.a     = r_a_q;

    assign o_bwr.en   = ld_b_ok;
    assign o_bwr.col  = b_j;
    assign o_bwr.p    = b_p;
    assign o_bwr.data = i_req.element;

    assign o_rsp.valid     = r_ov;
    assign o_rsp.out_row   = r_orow;
    assign o_rsp.out_col   = r_ocol;
    assign o_rsp.dot_value = r_oval;
    assign o_rsp.last      = r_olast;

endmodule

// ===== src/matrix_multiply_engine.sv =====
// Matrix multiply engine: a load request is taken in the idle state. A compute request holds the input
// (ready low) until its results have gone into the output register: the A row is streamed into the
// cell row, the controller waits until it sees the last column's sum, then the column sums are
// loaded into the output register one by one as the sink takes them (zeros when inner is zero).
// Synchronous active-low reset restores the size registers and idles control; stores are kept.
module matrix_multiply_engine #(
    parameter int MAX_DIM = mme_pkg::DEF_MAX_DIM
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mme_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mme_req_if.sink                         i_req,
    mme_rsp_if.source                       o_rsp
);
    import mme_pkg::*;

    localparam int CAP = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;

    t_feed                   w_feed [CAP+1];
    t_bwr                    w_bwr;
    logic signed [DOT_W-1:0] w_acc [CAP];
    logic [CAP-1:0]          w_done;

    mme_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .o_feed     (w_feed[0]),
        .o_bwr      (w_bwr),
        .i_acc      (w_acc),
        .i_done     (w_done)
    );

    for (genvar j = 0; j < CAP; j++) begin : g_cell
        mme_cell #(
            .MAX_DIM  (MAX_DIM),
            .CELL_IDX (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_feed  (w_feed[j]),
            .i_bwr   (w_bwr),
            .o_feed  (w_feed[j+1]),
            .o_acc   (w_acc[j]),
            .o_done  (w_done[j])
        );
    end

endmodule

// ===== dv/tb_matrix_multiply_engine.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for matrix_multiply_engine: element loads, row computes and size changes.
// Depends on mme_pkg, mme_req_if, mme_rsp_if and the engine RTL; it keeps its own matrix predictor.
module tb_matrix_multiply_engine;
    import mme_pkg::*;

    localparam int DIM           = DEF_MAX_DIM;
    localparam int DIM_CAP       = (DIM < DIM_LIMIT) ? DIM : DIM_LIMIT;
    localparam int IDLE_PCT      = 22;
    localparam int SETTLE_CYCLES = 80;
    localparam int RAND_ITEMS    = 120;
    localparam int MAX_REPORTS   = 40;
    localparam int TIMEOUT_NS    = 10_000_000;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  ri;
        logic [IDX_W-1:0]  ci;
        logic [ELEM_W-1:0] elem;
    } t_mm_request;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [DOT_W-1:0] dot;
        logic                    last;
    } t_product;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mme_req_if req_ch ();
    mme_rsp_if rsp_ch ();

    matrix_multiply_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // Size registers as last written, shared by the generator and the predictor.
    logic [CNT_W-1:0] cfg_rows  = COUNT_RESET;
    logic [CNT_W-1:0] cfg_cols  = COUNT_RESET;
    logic [CNT_W-1:0] cfg_inner = COUNT_RESET;
    logic             cfg_trans = 1'b0;

    logic signed [ELEM_W-1:0] a_mem [DIM*DIM];
    logic signed [ELEM_W-1:0] b_mem [DIM*DIM];
    bit a_done [DIM*DIM];
    bit b_done [DIM*DIM];

    t_mm_request pending_reqs [$];
    t_product    expected_products [$];

    bit   calm      = 1'b0;
    logic req_taken = 1'b0;
    int   err_cnt      = 0;
    int   req_cnt      = 0;
    int   product_cnt  = 0;
    int   setting_cnt  = 0;
    int   rand_cnt     = 0;

    function automatic int eff_count(logic [CNT_W-1:0] v);
        return (v > DIM_CAP) ? DIM_CAP : int'(v);
    endfunction

    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // True when every A and B entry that a compute of row r reads has been loaded.
    function automatic bit row_ready(int r);
        int inner;
        int cols;
        inner = eff_count(cfg_inner);
        cols  = eff_count(cfg_cols);
        for (int p = 0; p < inner; p++) begin
            if (!a_done[r*DIM+p]) return 1'b0;
            for (int j = 0; j < cols; j++) begin
                if (!b_done[p*DIM+j]) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Queues one request and returns 1 if it is a load or compute with indices within the sizes. Computes that
    // would read an entry never loaded are dropped here.
    function automatic bit queue_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] ri,
                                         logic [IDX_W-1:0] ci, logic [ELEM_W-1:0] elem);
        int rows;
        int cols;
        int inner;
        int p;
        int j;
        bit hit;
        rows  = eff_count(cfg_rows);
        cols  = eff_count(cfg_cols);
        inner = eff_count(cfg_inner);
        hit   = 1'b0;
        case (op)
            OP_LOAD_A: begin
                if (ri < rows && ci < inner) begin
                    a_done[ri*DIM+ci] = 1'b1;
                    hit = 1'b1;
                end
            end
            OP_LOAD_B: begin
                p = cfg_trans ? int'(ci) : int'(ri);
                j = cfg_trans ? int'(ri) : int'(ci);
                if (p < inner && j < cols) begin
                    b_done[p*DIM+j] = 1'b1;
                    hit = 1'b1;
                end
            end
            OP_COMPUTE: begin
                if (ri < rows) begin
                    if (!row_ready(ri)) return 1'b0;
                    hit = 1'b1;
                end
            end
            default: ;
        endcase
        pending_reqs.push_back('{op: op, ri: ri, ci: ci, elem: elem});
        return hit;
    endfunction

    // Applies an accepted request to the matrix copies and queues the product row it yields.
    function automatic void apply_to_matrices(t_mm_request rq);
        int rows;
        int cols;
        int inner;
        int p;
        int j;
        longint acc;
        t_product item;
        rows  = eff_count(cfg_rows);
        cols  = eff_count(cfg_cols);
        inner = eff_count(cfg_inner);
        case (rq.op)
            OP_LOAD_A: begin
                if (rq.ri < rows && rq.ci < inner) a_mem[rq.ri*DIM+rq.ci] = rq.elem;
            end
            OP_LOAD_B: begin
                p = cfg_trans ? int'(rq.ci) : int'(rq.ri);
                j = cfg_trans ? int'(rq.ri) : int'(rq.ci);
                if (p < inner && j < cols) b_mem[p*DIM+j] = rq.elem;
            end
            OP_COMPUTE: begin
                if (rq.ri < rows) begin
                    for (j = 0; j < cols; j++) begin
                        acc = 0;
                        for (p = 0; p < inner; p++) begin
                            acc += longint'(a_mem[rq.ri*DIM+p]) * longint'(b_mem[p*DIM+j]);
                        end
                        item.row  = rq.ri;
                        item.col  = j[IDX_W-1:0];
                        item.dot  = acc[DOT_W-1:0];
                        item.last = (j + 1 == cols);
                        expected_products.push_back(item);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            if (err_cnt < MAX_REPORTS) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
            err_cnt++;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_matrix_multiply_engine: errors");
        $finish;
    end

    // Request driver: a new request goes out only once the previous one was taken.
    always @(negedge i_clk) begin : req_driver
        t_mm_request nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = pending_reqs.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.op        <= nxt.op;
                req_ch.row_index <= nxt.ri;
                req_ch.col_index <= nxt.ci;
                req_ch.element   <= nxt.elem;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : rsp_stall
        rsp_ch.ready <= i_rst_n && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin : req_tap
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready) begin
                apply_to_matrices('{op: req_ch.op, ri: req_ch.row_index,
                                    ci: req_ch.col_index, elem: req_ch.element});
                req_cnt++;
            end
        end
    end

    always @(posedge i_clk) begin : product_check
        t_product want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            product_cnt++;
            if (expected_products.size() == 0) begin
                if (err_cnt < MAX_REPORTS) begin
                    $display("%0t ns: unexpected product, expected none, actual row %0d col %0d dot %0d",
                             $time, rsp_ch.out_row, rsp_ch.out_col, rsp_ch.dot_value);
                end
                err_cnt++;
            end else begin
                want = expected_products.pop_front();
                check_field("out_row", want.row, rsp_ch.out_row);
                check_field("out_col", want.col, rsp_ch.out_col);
                check_field("dot_value", $signed(want.dot), $signed(rsp_ch.dot_value));
                check_field("last", want.last, rsp_ch.last);
            end
        end
    end

    task automatic write_config(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols,
                                input logic [CNT_W-1:0] inner, input logic trans);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ROWS;
        i_cfg_data <= rows;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_COLS;
        i_cfg_data <= cols;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_INNER;
        i_cfg_data <= inner;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_TRANS;
        i_cfg_data <= {{(CFG_DATA_W-1){1'b0}}, trans};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_rows  = rows;
        cfg_cols  = cols;
        cfg_inner = inner;
        cfg_trans = trans;
        setting_cnt++;
    endtask

    // Returns once every request is taken, every product has arrived and the engine has settled.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || req_ch.valid || expected_products.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols,
                                input logic [CNT_W-1:0] inner, input logic trans);
        int got;
        int target;
        int pick;
        int r;
        int p;
        int j;
        write_config(rows, cols, inner, trans);
        got = 0;
        // The whole of B goes in first so that any row with its A entries can be computed.
        for (p = 0; p < eff_count(inner); p++) begin
            for (j = 0; j < eff_count(cols); j++) begin
                got += queue_request(OP_LOAD_B, IDX_W'(trans ? j : p), IDX_W'(trans ? p : j),
                                     rand_elem());
            end
        end
        target = got + $urandom_range(15, 35);
        while (got < target) begin
            pick = $urandom_range(0, 99);
            r    = $urandom_range(0, eff_count(rows) - 1);
            if (pick < 15) begin
                got += queue_request(OP_W'($urandom_range(0, 3)), IDX_W'($urandom),
                                     IDX_W'($urandom), ELEM_W'($urandom));
            end else if (pick < 25) begin
                p = $urandom_range(0, eff_count(inner) - 1);
                j = $urandom_range(0, eff_count(cols) - 1);
                got += queue_request(OP_LOAD_B, IDX_W'(trans ? j : p), IDX_W'(trans ? p : j),
                                     rand_elem());
            end else if (pick < 70) begin
                for (p = 0; p < eff_count(inner); p++) begin
                    got += queue_request(OP_LOAD_A, IDX_W'(r), IDX_W'(p), rand_elem());
                end
                got += queue_request(OP_COMPUTE, IDX_W'(r), IDX_W'($urandom), ELEM_W'($urandom));
            end else begin
                got += queue_request(OP_COMPUTE, IDX_W'(r), IDX_W'($urandom), ELEM_W'($urandom));
            end
        end
        rand_cnt += got;
        wait_idle();
    endtask

    initial begin : stimulus
        int ph;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        req_ch.valid     = 1'b0;
        req_ch.op        = '0;
        req_ch.row_index = '0;
        req_ch.col_index = '0;
        req_ch.element   = '0;
        rsp_ch.ready     = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Full-scale operands, then loads and computes that fall outside the sizes and an unused opcode.
        write_config(5'd2, 5'd2, 5'd2, 1'b0);
        void'(queue_request(OP_LOAD_A, 0, 0, 16'h7FFF));
        void'(queue_request(OP_LOAD_A, 0, 1, 16'h8000));
        void'(queue_request(OP_LOAD_A, 1, 0, 16'h8000));
        void'(queue_request(OP_LOAD_A, 1, 1, 16'h8000));
        void'(queue_request(OP_LOAD_B, 0, 0, 16'h8000));
        void'(queue_request(OP_LOAD_B, 1, 0, 16'h8000));
        void'(queue_request(OP_LOAD_B, 0, 1, 16'h7FFF));
        void'(queue_request(OP_LOAD_B, 1, 1, 16'hFFFF));
        void'(queue_request(OP_COMPUTE, 0, 0, 0));
        void'(queue_request(OP_COMPUTE, 1, 15, 16'hFFFF));
        void'(queue_request(OP_LOAD_A, 2, 0, 16'h1234));
        void'(queue_request(OP_LOAD_B, 0, 2, 16'h1234));
        void'(queue_request(OP_SPARE, 15, 15, 16'hFFFF));
        void'(queue_request(OP_COMPUTE, 2, 0, 0));
        wait_idle();

        // Transposed B: the first index is the column, the second the inner position.
        write_config(5'd1, 5'd3, 5'd2, 1'b1);
        void'(queue_request(OP_LOAD_B, 0, 0, 16'h0101));
        void'(queue_request(OP_LOAD_B, 0, 1, 16'hFF00));
        void'(queue_request(OP_LOAD_B, 1, 0, 16'h7FFF));
        void'(queue_request(OP_LOAD_B, 1, 1, 16'h8000));
        void'(queue_request(OP_LOAD_B, 2, 0, 16'h0003));
        void'(queue_request(OP_LOAD_B, 2, 1, 16'hFFFD));
        void'(queue_request(OP_LOAD_B, 3, 0, 16'h5555));
        void'(queue_request(OP_COMPUTE, 0, 0, 0));
        wait_idle();

        // Zero and oversized counts.
        write_config(5'd20, 5'd0, 5'd2, 1'b0);
        void'(queue_request(OP_COMPUTE, 0, 0, 0));
        wait_idle();
        write_config(5'd31, 5'd3, 5'd0, 1'b0);
        void'(queue_request(OP_COMPUTE, 15, 0, 0));
        wait_idle();
        write_config(5'd0, 5'd1, 5'd1, 1'b0);
        void'(queue_request(OP_COMPUTE, 0, 0, 0));
        wait_idle();

        ph = 0;
        while (rand_cnt < RAND_ITEMS) begin
            calm = (ph == 2);
            case (ph)
                0: random_phase(5'd16, 5'd16, 5'd1, 1'b0);
                1: random_phase(5'd16, 5'd1, 5'd16, 1'b1);
                default: random_phase(CNT_W'($urandom_range(1, 16)), CNT_W'($urandom_range(1, 6)),
                                      CNT_W'($urandom_range(1, 6)), 1'($urandom_range(0, 1)));
            endcase
            ph++;
        end
        calm = 1'b0;

        $display("Run covered %0d requests and %0d product elements under %0d size settings,",
                 req_cnt, product_cnt, setting_cnt);
        $display("including transposed B, oversized and zero counts, and ignored requests.");
        if (expected_products.size() != 0) begin
            $display("%0t ns: %0d expected products never arrived", $time,
                     expected_products.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("tb_matrix_multiply_engine: clean");
        end else begin
            $display("tb_matrix_multiply_engine: errors");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/mme_pkg.sv
src/mme_req_if.sv
src/mme_rsp_if.sv
src/mme_cell.sv
src/mme_ctrl.sv
src/matrix_multiply_engine.sv
dv/tb_matrix_multiply_engine.sv
